// File: rtl/fkh_pkg.sv
`timescale 1ns / 1ps

package fkh_pkg;

  // Histogram size: 2^BIN_BITS bins per counter array.
  localparam int BIN_BITS = 16;
  localparam int NUM_BINS = 1 << BIN_BITS;

  localparam int CNT_W      = 64;
  localparam int KEY_MODE_W = 5;
  localparam int IN_DATA_W  = 224;
  localparam int OUT_DATA_W = 200;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Request opcodes as they arrive in tuser.
  localparam logic [1:0] OP_ACCUMULATE  = 2'd0;
  localparam logic [1:0] OP_READ_BIN    = 2'd1;
  localparam logic [1:0] OP_READ_TOTALS = 2'd2;

  // Key selection codes.
  localparam logic [4:0] MODE_SIP_FIRST8  = 5'd0;
  localparam logic [4:0] MODE_SIP_FIRST16 = 5'd1;
  localparam logic [4:0] MODE_SIP_FIRST24 = 5'd2;
  localparam logic [4:0] MODE_SIP_LAST8   = 5'd3;
  localparam logic [4:0] MODE_SIP_LAST16  = 5'd4;
  localparam logic [4:0] MODE_DIP_FIRST8  = 5'd5;
  localparam logic [4:0] MODE_DIP_FIRST16 = 5'd6;
  localparam logic [4:0] MODE_DIP_FIRST24 = 5'd7;
  localparam logic [4:0] MODE_DIP_LAST8   = 5'd8;
  localparam logic [4:0] MODE_DIP_LAST16  = 5'd9;
  localparam logic [4:0] MODE_SPORT       = 5'd10;
  localparam logic [4:0] MODE_DPORT       = 5'd11;
  localparam logic [4:0] MODE_PROTO       = 5'd12;
  localparam logic [4:0] MODE_PACKETS     = 5'd13;
  localparam logic [4:0] MODE_BYTES       = 5'd14;
  localparam logic [4:0] MODE_ELAPSED     = 5'd15;
  localparam logic [4:0] MODE_ICMP        = 5'd16;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_KEY_MODE      = 3'd0;
  localparam logic [2:0] REG_RECORDS_LOWER = 3'd1;
  localparam logic [2:0] REG_RECORDS_UPPER = 3'd2;
  localparam logic [2:0] REG_BYTES_LOWER   = 3'd3;
  localparam logic [2:0] REG_BYTES_UPPER   = 3'd4;
  localparam logic [2:0] REG_PACKETS_LOWER = 3'd5;
  localparam logic [2:0] REG_PACKETS_UPPER = 3'd6;

  typedef enum logic [1:0] {
    CMD_ACCUMULATE,
    CMD_READ_BIN,
    CMD_READ_VOID,
    CMD_READ_TOTALS
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [BIN_BITS-1:0]   index;
    logic [31:0]           byte_count;
    logic [31:0]           packet_count;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] packets;
    logic [CNT_W-1:0] bytes;
    logic [CNT_W-1:0] records;
  } bin_word_t;

  typedef struct packed {
    logic [CNT_W-1:0] records_lower;
    logic [CNT_W-1:0] records_upper;
    logic [CNT_W-1:0] bytes_lower;
    logic [CNT_W-1:0] bytes_upper;
    logic [CNT_W-1:0] packets_lower;
    logic [CNT_W-1:0] packets_upper;
  } bounds_t;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_EXEC,
    B_SUM
  } back_state_t;

  // Number of key bits a mode can produce; zero for unused modes.
  function automatic logic [4:0] mode_key_bits(input logic [4:0] mode);
    logic [4:0] bits;
    case (mode)
      MODE_SIP_FIRST8, MODE_SIP_LAST8, MODE_DIP_FIRST8, MODE_DIP_LAST8,
      MODE_PROTO: bits = 5'd8;
      MODE_SIP_FIRST16, MODE_SIP_LAST16, MODE_DIP_FIRST16, MODE_DIP_LAST16,
      MODE_SPORT, MODE_DPORT, MODE_ICMP: bits = 5'd16;
      MODE_SIP_FIRST24, MODE_DIP_FIRST24, MODE_PACKETS,
      MODE_BYTES: bits = 5'd24;
      MODE_ELAPSED: bits = 5'd12;
      default: bits = 5'd0;
    endcase
    return bits;
  endfunction

endpackage

// File: rtl/fkh_front.sv
`timescale 1ns / 1ps

module fkh_front (
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [fkh_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic [1:0]                      s_tuser,
  input  logic [fkh_pkg::KEY_MODE_W-1:0]  key_mode,
  input  logic                            clear_busy,
  input  logic                            q_full,
  output logic                            push,
  output fkh_pkg::cmd_t                   push_cmd
);
  import fkh_pkg::*;

  logic [31:0] source_addr;
  logic [31:0] dest_addr;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [7:0]  protocol;
  logic [31:0] packet_count;
  logic [31:0] byte_count;
  logic [22:0] elapsed_seconds;
  logic [15:0] icmp_type_code;
  logic [15:0] bin_index;

  logic [31:0] raw_key;
  logic [4:0]  mode_bits;
  logic [4:0]  limit_bits;
  logic [31:0] key_mask;
  logic [31:0] key;
  logic [31:0] read_wide;
  logic        read_in_range;
  logic        accepted;

  assign source_addr     = s_tdata[31:0];
  assign dest_addr       = s_tdata[63:32];
  assign source_port     = s_tdata[79:64];
  assign dest_port       = s_tdata[95:80];
  assign protocol        = s_tdata[103:96];
  assign packet_count    = s_tdata[135:104];
  assign byte_count      = s_tdata[167:136];
  assign elapsed_seconds = s_tdata[190:168];
  assign icmp_type_code  = s_tdata[206:191];
  assign bin_index       = s_tdata[222:207];

  assign s_tready = !q_full && !clear_busy;
  assign accepted = s_tvalid && s_tready;

  always_comb begin
    case (key_mode)
      MODE_SIP_FIRST8:  raw_key = {24'd0, source_addr[31:24]};
      MODE_SIP_FIRST16: raw_key = {16'd0, source_addr[31:16]};
      MODE_SIP_FIRST24: raw_key = {8'd0, source_addr[31:8]};
      MODE_SIP_LAST8:   raw_key = {24'd0, source_addr[7:0]};
      MODE_SIP_LAST16:  raw_key = {16'd0, source_addr[15:0]};
      MODE_DIP_FIRST8:  raw_key = {24'd0, dest_addr[31:24]};
      MODE_DIP_FIRST16: raw_key = {16'd0, dest_addr[31:16]};
      MODE_DIP_FIRST24: raw_key = {8'd0, dest_addr[31:8]};
      MODE_DIP_LAST8:   raw_key = {24'd0, dest_addr[7:0]};
      MODE_DIP_LAST16:  raw_key = {16'd0, dest_addr[15:0]};
      MODE_SPORT:       raw_key = {16'd0, source_port};
      MODE_DPORT:       raw_key = {16'd0, dest_port};
      MODE_PROTO:       raw_key = {24'd0, protocol};
      MODE_PACKETS:     raw_key = packet_count;
      MODE_BYTES:       raw_key = byte_count;
      MODE_ELAPSED:     raw_key = {9'd0, elapsed_seconds};
      default:          raw_key = {16'd0, icmp_type_code};
    endcase
  end

  // Keys past the last bin of the mode fold into that last bin.
  always_comb begin
    mode_bits  = mode_key_bits(key_mode);
    limit_bits = (mode_bits > 5'(BIN_BITS)) ? 5'(BIN_BITS) : mode_bits;
    key_mask   = 32'((33'd1 << limit_bits) - 33'd1);
    key        = ((raw_key & ~key_mask) != 32'd0) ? key_mask : raw_key;
  end

  assign read_wide     = {16'd0, bin_index};
  assign read_in_range = (read_wide >> BIN_BITS) == 32'd0;

  always_comb begin
    push                  = 1'b0;
    push_cmd.kind         = CMD_ACCUMULATE;
    push_cmd.index        = key[BIN_BITS-1:0];
    push_cmd.byte_count   = byte_count;
    push_cmd.packet_count = packet_count;
    case (s_tuser)
      OP_ACCUMULATE: begin
        push = accepted && (mode_bits != 5'd0);
      end
      OP_READ_BIN: begin
        push           = accepted;
        push_cmd.kind  = read_in_range ? CMD_READ_BIN : CMD_READ_VOID;
        push_cmd.index = read_wide[BIN_BITS-1:0];
      end
      OP_READ_TOTALS: begin
        push          = accepted;
        push_cmd.kind = CMD_READ_TOTALS;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

endmodule

// File: rtl/fkh_queue.sv
`timescale 1ns / 1ps

module fkh_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  fkh_pkg::cmd_t push_cmd,
  input  logic          pop,
  output fkh_pkg::cmd_t head,
  output logic          full,
  output logic          empty
);
  import fkh_pkg::*;

  cmd_t                slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full  = count == (QUEUE_AW + 1)'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/fkh_back.sv
`timescale 1ns / 1ps

module fkh_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_empty,
  input  fkh_pkg::cmd_t                   q_head,
  output logic                            pop,
  input  fkh_pkg::bounds_t                bounds,
  output logic                            clear_busy,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [fkh_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                            m_tuser
);
  import fkh_pkg::*;

  bin_word_t           mem [NUM_BINS];
  bin_word_t           rd_data;

  back_state_t         state;
  back_state_t         state_next;
  logic [BIN_BITS-1:0] clear_addr;
  cmd_t                cmd;

  logic [CNT_W-1:0]    sum_records;
  logic [CNT_W-1:0]    sum_bytes;
  logic [CNT_W-1:0]    sum_packets;

  logic [CNT_W-1:0]    out_records;
  logic [CNT_W-1:0]    out_bytes;
  logic [CNT_W-1:0]    out_packets;
  logic                out_within;
  logic                out_totals;

  logic                out_free;
  logic                rd_en;
  logic                wr_en;
  logic [BIN_BITS-1:0] wr_addr;
  bin_word_t           wr_data;
  logic                load_bin;
  logic                load_void;
  logic                load_totals;
  logic                add_sums;
  logic                in_bounds;

  assign out_free   = !m_tvalid || m_tready;
  assign clear_busy = state == B_CLEAR;

  assign m_tdata = {7'd0, out_within, out_packets, out_bytes, out_records};
  assign m_tuser = out_totals;

  assign in_bounds = (rd_data.records >= bounds.records_lower) &&
                     (rd_data.records <= bounds.records_upper) &&
                     (rd_data.bytes   >= bounds.bytes_lower)   &&
                     (rd_data.bytes   <= bounds.bytes_upper)   &&
                     (rd_data.packets >= bounds.packets_lower) &&
                     (rd_data.packets <= bounds.packets_upper);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[q_head.index];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    pop         = 1'b0;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = cmd.index;
    wr_data     = '0;
    load_bin    = 1'b0;
    load_void   = 1'b0;
    load_totals = 1'b0;
    add_sums    = 1'b0;
    case (state)
      B_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clear_addr;
        if (clear_addr == '1) begin
          state_next = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!q_empty) begin
          case (q_head.kind)
            CMD_ACCUMULATE: begin
              pop        = 1'b1;
              rd_en      = 1'b1;
              state_next = B_EXEC;
            end
            CMD_READ_BIN: begin
              if (out_free) begin
                pop        = 1'b1;
                rd_en      = 1'b1;
                state_next = B_EXEC;
              end
            end
            CMD_READ_TOTALS: begin
              pop         = out_free;
              load_totals = out_free;
            end
            default: begin
              pop       = out_free;
              load_void = out_free;
            end
          endcase
        end
      end
      B_EXEC: begin
        if (cmd.kind == CMD_ACCUMULATE) begin
          wr_en           = 1'b1;
          wr_data.records = rd_data.records + CNT_W'(1);
          wr_data.bytes   = rd_data.bytes + CNT_W'(cmd.byte_count);
          wr_data.packets = rd_data.packets + CNT_W'(cmd.packet_count);
          state_next      = B_IDLE;
        end else begin
          load_bin   = 1'b1;
          state_next = in_bounds ? B_SUM : B_IDLE;
        end
      end
      B_SUM: begin
        add_sums   = 1'b1;
        state_next = B_IDLE;
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr  <= '0;
      sum_records <= '0;
      sum_bytes   <= '0;
      sum_packets <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (state == B_CLEAR) begin
        clear_addr <= clear_addr + 1'b1;
      end
      if (add_sums) begin
        sum_records <= sum_records + out_records;
        sum_bytes   <= sum_bytes + out_bytes;
        sum_packets <= sum_packets + out_packets;
      end
      if (load_bin || load_void || load_totals) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= q_head;
    end
    if (load_bin) begin
      out_records <= rd_data.records;
      out_bytes   <= rd_data.bytes;
      out_packets <= rd_data.packets;
      out_within  <= in_bounds;
      out_totals  <= 1'b0;
    end else if (load_void) begin
      out_records <= '0;
      out_bytes   <= '0;
      out_packets <= '0;
      out_within  <= 1'b0;
      out_totals  <= 1'b0;
    end else if (load_totals) begin
      out_records <= sum_records;
      out_bytes   <= sum_bytes;
      out_packets <= sum_packets;
      out_within  <= 1'b0;
      out_totals  <= 1'b1;
    end
  end

endmodule

// File: rtl/flow_key_histogram_unit.sv
`timescale 1ns / 1ps

// Flow-record histogram engine.
// Requests enter on the s_ stream: tuser holds the opcode (accumulate, read bin,
// read totals) and tdata the flow record fields and the bin index. Results leave
// on the m_ stream: tdata holds the three counters and the in-bounds flag, tuser
// marks a totals result. Accumulate requests and unused opcodes give no result.
// The key mode and the six bounds are written through the APB port at 8*index;
// change them only while no request is in flight.
// A decode stage derives the bin from the record and pushes a command into a
// four-entry queue; the counter engine drains the queue one command at a time.
// An accumulate is a memory read, then add and write back; a bin read is a
// memory read, then the result load, then, if the bin is in bounds, a step
// that adds it to the totals; a totals read or an out-of-range bin read loads
// the result from idle. The engine takes a new command only when done with
// the last. Each result is registered before it leaves on the m_ stream.
// After reset the engine sweeps all 65536 counter bins to zero, one bin per
// cycle; s_tready stays low during the sweep, while APB writes are taken.
// A stalled receiver holds the result register; the queue keeps accepting until
// it fills, then s_tready drops.
module flow_key_histogram_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // source_addr, dest_addr, source_port, dest_port, protocol, packet_count,
  // byte_count, elapsed_seconds, icmp_type_code, bin_index, zero pad
  input  logic [223:0] s_tdata,
  // opcode
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // record_total, byte_total, packet_total, within_bounds, zero pad
  output logic [199:0] m_tdata,
  // is_totals
  output logic         m_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);
  import fkh_pkg::*;

  logic [KEY_MODE_W-1:0] key_mode;
  bounds_t               bounds;
  logic [2:0]            reg_index;
  logic                  reg_write;

  logic                  clear_busy;
  logic                  push;
  cmd_t                  push_cmd;
  logic                  pop;
  cmd_t                  q_head;
  logic                  q_full;
  logic                  q_empty;

  assign pready    = 1'b1;
  assign reg_index = paddr[5:3];
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_mode             <= '0;
      bounds.records_lower <= '0;
      bounds.records_upper <= '1;
      bounds.bytes_lower   <= '0;
      bounds.bytes_upper   <= '1;
      bounds.packets_lower <= '0;
      bounds.packets_upper <= '1;
    end else if (reg_write) begin
      case (reg_index)
        REG_KEY_MODE:      key_mode             <= pwdata[KEY_MODE_W-1:0];
        REG_RECORDS_LOWER: bounds.records_lower <= pwdata;
        REG_RECORDS_UPPER: bounds.records_upper <= pwdata;
        REG_BYTES_LOWER:   bounds.bytes_lower   <= pwdata;
        REG_BYTES_UPPER:   bounds.bytes_upper   <= pwdata;
        REG_PACKETS_LOWER: bounds.packets_lower <= pwdata;
        REG_PACKETS_UPPER: bounds.packets_upper <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_KEY_MODE:      prdata = {59'd0, key_mode};
      REG_RECORDS_LOWER: prdata = bounds.records_lower;
      REG_RECORDS_UPPER: prdata = bounds.records_upper;
      REG_BYTES_LOWER:   prdata = bounds.bytes_lower;
      REG_BYTES_UPPER:   prdata = bounds.bytes_upper;
      REG_PACKETS_LOWER: prdata = bounds.packets_lower;
      REG_PACKETS_UPPER: prdata = bounds.packets_upper;
      default:           prdata = '0;
    endcase
  end

  fkh_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .key_mode   (key_mode),
    .clear_busy (clear_busy),
    .q_full     (q_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  fkh_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  fkh_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .pop        (pop),
    .bounds     (bounds),
    .clear_busy (clear_busy),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule
